// ----- rtl/core/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// One decoded input byte: up to four result bytes, sent in order bytes[0] first.
	typedef struct packed {
		logic [1:0]      kind;
		logic [2:0]      cnt;
		logic [3:0][7:0] bytes;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

// ----- rtl/core/jsu_text_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_text_if
// Raw character channel: one JSON character per transfer.
// ----------------------------------------------------------------------------
interface jsu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/jsu_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_result_if
// Result channel: one decoded byte or status per transfer.
// ----------------------------------------------------------------------------
interface jsu_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_byte, output kind, output last, input ready);
	modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- rtl/core/jsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one character per cycle unless the queue is full and
// turns it into a result command (0-4 UTF-8 bytes, an end mark or an error).
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	jsu_text_if.sink       text,
	input  logic           q_full,
	output jsu_pkg::push_t wr
);

	localparam logic [2:0] MODE_WAIT     = 3'd0;
	localparam logic [2:0] MODE_OPEN     = 3'd1;
	localparam logic [2:0] MODE_ESC      = 3'd2;
	localparam logic [2:0] MODE_HEX1     = 3'd3;
	localparam logic [2:0] MODE_NEED_BSL = 3'd4;
	localparam logic [2:0] MODE_NEED_U   = 3'd5;
	localparam logic [2:0] MODE_HEX2     = 3'd6;

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hs_q, hs_d;

	logic        acc_fire;
	logic [7:0]  c;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] v;
	logic [20:0] cp;
	jsu_pkg::cmd_t cmd;

	assign text.ready = !q_full;
	assign acc_fire   = text.valid && text.ready;
	assign c          = text.in_byte;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_val = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_val = 4'(c - 8'h57);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign v  = {acc_q[11:0], hex_val};
	assign cp = {1'b0, hs_q, v[9:0]} + 21'h10000;

	always_comb begin
		mode_d     = mode_q;
		digits_d   = digits_q;
		acc_d      = acc_q;
		hs_d       = hs_q;
		cmd.kind   = jsu_pkg::KIND_DATA;
		cmd.cnt    = 3'd0;
		cmd.bytes  = '0;
		case (mode_q)
			MODE_OPEN: begin
				if (c == 8'h22) begin
					cmd.kind = jsu_pkg::KIND_END;
					cmd.cnt  = 3'd1;
					mode_d   = MODE_WAIT;
				end else if (c == 8'h5c) begin
					mode_d = MODE_ESC;
				end else begin
					cmd.cnt      = 3'd1;
					cmd.bytes[0] = c;
				end
			end
			MODE_ESC: begin
				mode_d  = MODE_OPEN;
				cmd.cnt = 3'd1;
				case (c)
					8'h22, 8'h5c, 8'h2f: cmd.bytes[0] = c;
					8'h62: cmd.bytes[0] = 8'h08;
					8'h66: cmd.bytes[0] = 8'h0c;
					8'h6e: cmd.bytes[0] = 8'h0a;
					8'h72: cmd.bytes[0] = 8'h0d;
					8'h74: cmd.bytes[0] = 8'h09;
					8'h75: begin
						cmd.cnt  = 3'd0;
						mode_d   = MODE_HEX1;
						digits_d = 2'd0;
						acc_d    = '0;
					end
					default: begin
						cmd.kind = jsu_pkg::KIND_ERROR;
						mode_d   = MODE_WAIT;
					end
				endcase
			end
			MODE_HEX1, MODE_HEX2: begin
				if (!hex_ok) begin
					cmd.kind = jsu_pkg::KIND_ERROR;
					cmd.cnt  = 3'd1;
					mode_d   = MODE_WAIT;
				end else if (digits_q != 2'd3) begin
					acc_d    = v;
					digits_d = digits_q + 2'd1;
				end else begin
					acc_d    = '0;
					digits_d = 2'd0;
					mode_d   = MODE_OPEN;
					if (mode_q == MODE_HEX2) begin
						// second half of a pair must be a low surrogate
						if (v[15:10] != 6'b110111) begin
							cmd.kind = jsu_pkg::KIND_ERROR;
							cmd.cnt  = 3'd1;
							mode_d   = MODE_WAIT;
						end else begin
							cmd.cnt      = 3'd4;
							cmd.bytes[0] = {5'b11110, cp[20:18]};
							cmd.bytes[1] = {2'b10, cp[17:12]};
							cmd.bytes[2] = {2'b10, cp[11:6]};
							cmd.bytes[3] = {2'b10, cp[5:0]};
						end
					end else if (v < 16'h0080) begin
						cmd.cnt      = 3'd1;
						cmd.bytes[0] = v[7:0];
					end else if (v <= 16'h07ff) begin
						cmd.cnt      = 3'd2;
						cmd.bytes[0] = {3'b110, v[10:6]};
						cmd.bytes[1] = {2'b10, v[5:0]};
					end else if (v[15:10] == 6'b110110) begin
						hs_d   = v[9:0];
						mode_d = MODE_NEED_BSL;
					end else begin
						cmd.cnt      = 3'd3;
						cmd.bytes[0] = {4'b1110, v[15:12]};
						cmd.bytes[1] = {2'b10, v[11:6]};
						cmd.bytes[2] = {2'b10, v[5:0]};
					end
				end
			end
			MODE_NEED_BSL: begin
				if (c == 8'h5c) begin
					mode_d = MODE_NEED_U;
				end else begin
					cmd.kind = jsu_pkg::KIND_ERROR;
					cmd.cnt  = 3'd1;
					mode_d   = MODE_WAIT;
				end
			end
			MODE_NEED_U: begin
				if (c == 8'h75) begin
					mode_d   = MODE_HEX2;
					digits_d = 2'd0;
					acc_d    = '0;
				end else begin
					cmd.kind = jsu_pkg::KIND_ERROR;
					cmd.cnt  = 3'd1;
					mode_d   = MODE_WAIT;
				end
			end
			default: begin
				// outside a string, everything but the opening quote passes through
				if (c == 8'h22) begin
					mode_d = MODE_OPEN;
				end else begin
					cmd.cnt      = 3'd1;
					cmd.bytes[0] = c;
				end
			end
		endcase
		if (cmd.kind == jsu_pkg::KIND_ERROR) begin
			digits_d = 2'd0;
			acc_d    = '0;
			hs_d     = '0;
		end
	end

	assign wr.push = acc_fire && (cmd.cnt != 3'd0);
	assign wr.cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WAIT;
			digits_q <= 2'd0;
			acc_q    <= '0;
			hs_q     <= '0;
		end else if (acc_fire) begin
			mode_q   <= mode_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
			hs_q     <= hs_d;
		end
	end

endmodule

// ----- rtl/core/jsu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between the decoder and the byte serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  jsu_pkg::push_t wr,
	input  logic           pop,
	output logic           full,
	output jsu_pkg::head_t head
);

	jsu_pkg::cmd_t entry_q [jsu_pkg::QUEUE_DEPTH];

	logic [jsu_pkg::QPTR_W-1:0] wptr_q;
	logic [jsu_pkg::QPTR_W-1:0] rptr_q;
	logic [jsu_pkg::QPTR_W:0]   level_q;
	logic                       do_pop;

	assign full       = (level_q == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QUEUE_DEPTH));
	assign head.valid = (level_q != '0);
	assign head.cmd   = entry_q[rptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			entry_q[wptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr.push) begin
				wptr_q <= wptr_q + (jsu_pkg::QPTR_W)'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + (jsu_pkg::QPTR_W)'(1);
			end
			case ({wr.push, do_pop})
				2'b10:   level_q <= level_q + (jsu_pkg::QPTR_W+1)'(1);
				2'b01:   level_q <= level_q - (jsu_pkg::QPTR_W+1)'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/jsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Byte serializer: sends the head command one byte per transfer through an
// output register and retires it after its last byte.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jsu_pkg::head_t head,
	output logic           pop,
	jsu_result_if.source   result
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = head.valid && (!valid_q || result.ready);
	assign at_last = ({1'b0, idx_q} == (head.cmd.cnt - 3'd1));
	assign pop     = load && at_last;

	assign result.valid    = valid_q;
	assign result.out_byte = byte_q;
	assign result.kind     = kind_q;
	assign result.last     = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.cmd.bytes[idx_q];
			kind_q <= head.cmd.kind;
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/json_string_unescaper_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_utf8
// JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// The block takes one raw character per cycle on text while the queue has
// room and gives the unescaped string as UTF-8 bytes on result, one byte per
// transfer, with last set on the final result of each character. A character
// gives zero to four results; the result side sends one per cycle while result
// is ready, so a run of characters that each give one result flows at one
// character per cycle, while \u escapes that expand to two to four bytes hold
// the input back only when the four-entry command queue between decoder and
// serializer fills. The first result of a character passes through the command
// queue, written at the transfer, and then the output register.
// ----------------------------------------------------------------------------
module json_string_unescaper_utf8 (
	input  logic         clk,
	input  logic         arst_n,
	jsu_text_if.sink     text,
	jsu_result_if.source result
);

	jsu_pkg::push_t wr;
	jsu_pkg::head_t head;
	logic           q_full;
	logic           pop;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_full (q_full),
		.wr     (wr)
	);

	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

	// queued commands always carry at least one byte, status marks exactly one
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> head.cmd.cnt != 3'd0 && head.cmd.cnt <= 3'd4)
		else $error("queued command without results");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid && head.cmd.kind != jsu_pkg::KIND_DATA |-> head.cmd.cnt == 3'd1)
		else $error("status command with more than one result");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != jsu_pkg::KIND_DATA |-> result.last)
		else $error("status result not marked last");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !pop |-> !wr.push)
		else $error("push into full queue");

endmodule

// ----- bench/tb_json_string_unescaper_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_utf8
// Self-checking bench for the JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Feeds quoted JSON strings one character per transfer: a short directed run,
// then random strings with plain text, simple escapes, \u codes of every
// UTF-8 length, surrogate pairs, and broken escapes, plus stray bytes outside
// the quotes. A behavioral decoder predicts the UTF-8 bytes, end and error
// results of each accepted character. The monitor checks every result
// transfer in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_json_string_unescaper_utf8;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_CHARS = 320;
	localparam logic [7:0]  CH_QUOTE     = 8'h22;
	localparam logic [7:0]  CH_BSL       = 8'h5C;
	localparam logic [7:0]  CH_U         = "u";

	typedef enum logic [2:0] {
		M_WAIT, M_OPEN, M_ESC, M_HEX1, M_NEED_BSL, M_NEED_U, M_HEX2
	} dec_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} utf8_res_t;

	typedef struct {
		logic [7:0] ch;
		bit         drain;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_text_if   text_ch ();
	jsu_result_if result_ch ();

	json_string_unescaper_utf8 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_item_t  pending_chars[$];
	utf8_res_t   expected_utf8[$];
	int          failures    = 0;
	int unsigned chars_taken = 0;
	int unsigned cycles      = 0;

	// no random idling or stalls over this stretch of the run
	wire calm = (chars_taken >= 120) && (chars_taken < 220);

	// ---------------- decoder model ----------------
	dec_mode_t   dec_mode  = M_WAIT;
	logic [1:0]  hex_count = '0;
	logic [15:0] hex_code  = '0;
	logic [9:0]  high_bits = '0;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic void emit(input logic [7:0] b, input logic [1:0] k);
		utf8_res_t r;
		r.data = b;
		r.kind = k;
		r.last = 1'b0;
		expected_utf8.insert(expected_utf8.size(), r);
	endfunction

	function automatic void decode_error();
		dec_mode  = M_WAIT;
		hex_count = '0;
		hex_code  = '0;
		high_bits = '0;
		emit(8'h00, jsu_pkg::KIND_ERROR);
	endfunction

	function automatic void code_complete();
		logic [15:0] v;
		logic [20:0] cp;
		v = hex_code;
		hex_count = '0;
		hex_code  = '0;
		if (dec_mode == M_HEX2) begin
			if (v < 16'hDC00 || v > 16'hDFFF) begin
				decode_error();
				return;
			end
			cp = {1'b0, high_bits, v[9:0]} + 21'h10000;
			emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
			high_bits = '0;
			dec_mode  = M_OPEN;
		end else if (v < 16'h0080) begin
			emit(v[7:0], jsu_pkg::KIND_DATA);
			dec_mode = M_OPEN;
		end else if (v <= 16'h07FF) begin
			emit({3'b110, v[10:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, v[5:0]}, jsu_pkg::KIND_DATA);
			dec_mode = M_OPEN;
		end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
			high_bits = v[9:0];
			dec_mode  = M_NEED_BSL;
		end else begin
			emit({4'b1110, v[15:12]}, jsu_pkg::KIND_DATA);
			emit({2'b10, v[11:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, v[5:0]}, jsu_pkg::KIND_DATA);
			dec_mode = M_OPEN;
		end
	endfunction

	function automatic void unescape_char(input logic [7:0] c);
		int base;
		int d;
		base = expected_utf8.size();
		case (dec_mode)
			M_OPEN: begin
				if (c == CH_QUOTE) begin
					emit(8'h00, jsu_pkg::KIND_END);
					dec_mode = M_WAIT;
				end else if (c == CH_BSL)
					dec_mode = M_ESC;
				else
					emit(c, jsu_pkg::KIND_DATA);
			end
			M_ESC: begin
				dec_mode = M_OPEN;
				if (c == CH_QUOTE || c == CH_BSL || c == "/") emit(c, jsu_pkg::KIND_DATA);
				else if (c == "b") emit(8'h08, jsu_pkg::KIND_DATA);
				else if (c == "f") emit(8'h0C, jsu_pkg::KIND_DATA);
				else if (c == "n") emit(8'h0A, jsu_pkg::KIND_DATA);
				else if (c == "r") emit(8'h0D, jsu_pkg::KIND_DATA);
				else if (c == "t") emit(8'h09, jsu_pkg::KIND_DATA);
				else if (c == CH_U) begin
					dec_mode  = M_HEX1;
					hex_count = '0;
					hex_code  = '0;
				end else
					decode_error();
			end
			M_HEX1, M_HEX2: begin
				d = hex_nibble(c);
				if (d < 0)
					decode_error();
				else begin
					hex_code = {hex_code[11:0], 4'(d)};
					if (hex_count == 2'd3)
						code_complete();
					else
						hex_count = hex_count + 2'd1;
				end
			end
			M_NEED_BSL: begin
				if (c != CH_BSL) decode_error();
				else dec_mode = M_NEED_U;
			end
			M_NEED_U: begin
				if (c != CH_U)
					decode_error();
				else begin
					dec_mode  = M_HEX2;
					hex_count = '0;
					hex_code  = '0;
				end
			end
			default: begin
				if (c == CH_QUOTE) dec_mode = M_OPEN;
				else emit(c, jsu_pkg::KIND_DATA);
			end
		endcase
		if (expected_utf8.size() > base)
			expected_utf8[expected_utf8.size() - 1].last = 1'b1;
	endfunction

	// ---------------- stimulus ----------------
	function automatic void add_char(input logic [7:0] c);
		char_item_t it;
		it.ch    = c;
		it.drain = 1'b0;
		pending_chars.insert(pending_chars.size(), it);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return "0" + 8'(nib);
		return ($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10;
	endfunction

	function automatic void add_code(input logic [15:0] v);
		add_char(CH_BSL);
		add_char(CH_U);
		for (int i = 3; i >= 0; i--) add_char(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic logic [7:0] simple_escape();
		case ($urandom_range(7))
			0: return CH_QUOTE;
			1: return CH_BSL;
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	// any code that stands alone: 1, 2 or 3 UTF-8 bytes, lone low surrogate
	function automatic logic [15:0] single_code();
		logic [15:0] v;
		case ($urandom_range(4))
			0: v = 16'($urandom_range(16'h007F));
			1: v = 16'($urandom_range(16'h07FF, 16'h0080));
			2: begin
				do v = 16'($urandom_range(16'hFFFF, 16'h0800));
				while (v >= 16'hD800 && v <= 16'hDBFF);
			end
			3: v = 16'($urandom_range(16'hDFFF, 16'hDC00));
			default: begin
				case ($urandom_range(5))
					0: v = 16'h0000;
					1: v = 16'h007F;
					2: v = 16'h0080;
					3: v = 16'h07FF;
					4: v = 16'h0800;
					default: v = 16'hFFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
		return c;
	endfunction

	// one broken escape; the decoder falls back to waiting after it
	function automatic void add_broken();
		logic [7:0]  c;
		logic [15:0] v;
		int          pos;
		case ($urandom_range(5))
			0: begin
				add_char(CH_BSL);
				do c = 8'($urandom_range(255));
				while (c inside {CH_QUOTE, CH_BSL, "/", "b", "f", "n", "r", "t", CH_U});
				add_char(c);
			end
			1: begin
				add_char(CH_BSL);
				add_char(CH_U);
				pos = $urandom_range(3);
				for (int i = 0; i < pos; i++) add_char(hex_char(4'($urandom_range(15))));
				add_char(non_hex());
			end
			2: begin
				add_code(16'($urandom_range(16'hDBFF, 16'hD800)));
				do c = 8'($urandom_range(255)); while (c == CH_BSL);
				add_char(c);
			end
			3: begin
				add_code(16'($urandom_range(16'hDBFF, 16'hD800)));
				add_char(CH_BSL);
				do c = 8'($urandom_range(255)); while (c == CH_U);
				add_char(c);
			end
			4: begin
				add_code(16'($urandom_range(16'hDBFF, 16'hD800)));
				if ($urandom_range(1))
					v = 16'($urandom_range(16'hDBFF, 16'hD800));
				else
					do v = 16'($urandom_range(16'hFFFF));
					while (v >= 16'hDC00 && v <= 16'hDFFF);
				add_code(v);
			end
			default: begin
				add_code(16'($urandom_range(16'hDBFF, 16'hD800)));
				add_char(CH_BSL);
				add_char(CH_U);
				pos = $urandom_range(3);
				for (int i = 0; i < pos; i++) add_char(hex_char(4'($urandom_range(15))));
				add_char(non_hex());
			end
		endcase
	endfunction

	function automatic void add_string();
		logic [7:0] c;
		int         segs;
		int         sel;
		// stray bytes before the opening quote pass straight through
		repeat ($urandom_range(2)) begin
			c = 8'($urandom_range(255));
			if (c != CH_QUOTE) add_char(c);
		end
		add_char(CH_QUOTE);
		segs = $urandom_range(8, 1);
		for (int i = 0; i < segs; i++) begin
			sel = $urandom_range(99);
			if (sel < 40) begin
				do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSL);
				add_char(c);
			end else if (sel < 60) begin
				add_char(CH_BSL);
				add_char(simple_escape());
			end else if (sel < 82)
				add_code(single_code());
			else if (sel < 95) begin
				add_code(16'($urandom_range(16'hDBFF, 16'hD800)));
				add_code(16'($urandom_range(16'hDFFF, 16'hDC00)));
			end else begin
				add_broken();
				return;
			end
		end
		add_char(CH_QUOTE);
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin : text_driver
		char_item_t it;
		if (!arst_n) begin
			text_ch.valid   <= 1'b0;
			text_ch.in_byte <= 8'h00;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				unescape_char(text_ch.in_byte);
				chars_taken <= chars_taken + 1;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (pending_chars.size() != 0 &&
				    !(pending_chars[0].drain && expected_utf8.size() != 0) &&
				    (calm || $urandom_range(99) >= 25)) begin
					it = pending_chars.pop_front();
					text_ch.valid   <= 1'b1;
					text_ch.in_byte <= it.ch;
				end else
					text_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		utf8_res_t got;
		utf8_res_t want;
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else begin
			if (result_ch.valid && result_ch.ready) begin
				got.data = result_ch.out_byte;
				got.kind = result_ch.kind;
				got.last = result_ch.last;
				if (expected_utf8.size() == 0) begin
					$display("%0t: unexpected transfer: byte=%02h kind=%0d last=%0b",
						$time, got.data, got.kind, got.last);
					failures++;
				end else begin
					want = expected_utf8.pop_front();
					if (got !== want) begin
						$display({"%0t: mismatch: expected byte=%02h kind=%0d last=%0b,",
							" got byte=%02h kind=%0d last=%0b"},
							$time, want.data, want.kind, want.last,
							got.data, got.kind, got.last);
						failures++;
					end
				end
			end
			result_ch.ready <= calm || ($urandom_range(99) >= 25);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time, expected_utf8.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		int mark;
		arst_n = 1'b0;

		// pass-through extremes and a backslash before any quote
		add_char(8'h00);
		add_char(8'hFF);
		add_char(CH_BSL);
		add_char(CH_QUOTE);
		add_char(CH_BSL);
		add_char("n");
		add_code(16'h0000);
		add_code(16'hFFFF);
		add_code(16'hDBFF);
		add_code(16'hDC00);
		add_char(CH_QUOTE);
		// bad escape letter inside a fresh string
		add_char(CH_QUOTE);
		add_char(CH_BSL);
		add_char("q");

		mark = pending_chars.size();
		while (pending_chars.size() < mark + RANDOM_CHARS) add_string();
		// hold the sender until all results are out, twice
		pending_chars[mark].drain = 1'b1;
		pending_chars[mark + (pending_chars.size() - mark) / 2].drain = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || text_ch.valid || expected_utf8.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/jsu_pkg.sv
rtl/core/jsu_text_if.sv
rtl/core/jsu_result_if.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescaper_utf8.sv
bench/tb_json_string_unescaper_utf8.sv
